// File: hdl/bbp_pkg.sv
// ----------------------------------------------------------------------------
// bbp_pkg
// Shared types and constants of the bimodal branch predictor: the branch and
// result words, the table control group, the register map and the states.
// ----------------------------------------------------------------------------
package bbp_pkg;

  localparam int TABLE_ENTRIES_DEF    = 1024;
  localparam int MAX_COUNTER_BITS_DEF = 8;

  localparam int SEL_LSB  = 2;
  localparam int SEL_BITS = 10;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int CFG_W   = 4;

  localparam logic             REG_COUNTER_BITS = 1'b0;
  localparam logic [CFG_W-1:0] COUNTER_BITS_RST = 4'd2;

  typedef struct packed {
    logic [31:0] branch_address;
    logic        taken;
  } branch_word_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        prediction_correct;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } result_word_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } tbl_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_UPDATE
  } state_t;

endpackage

// File: hdl/bbp_table.sv
// ----------------------------------------------------------------------------
// bbp_table
// Single-port counter table with registered read data.
// ----------------------------------------------------------------------------
module bbp_table #(
  parameter int ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF,
  parameter int WIDTH   = bbp_pkg::MAX_COUNTER_BITS_DEF
) (
  input  logic                       clk,
  input  bbp_pkg::tbl_ctl_t          ctl,
  input  logic [$clog2(ENTRIES)-1:0] addr,
  input  logic [WIDTH-1:0]           wdata,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/bimodal_branch_predictor.sv
// ----------------------------------------------------------------------------
// bimodal_branch_predictor
// Bimodal predictor over a table of n-bit saturating counters.
// ----------------------------------------------------------------------------
// Each branch word passes three steps: accept, table read at the selected
// entry, then update and write-back while the result word is loaded. The
// single-port counter table sets these steps, one read and one write per
// branch. After reset the table is swept to zero, one entry a cycle, so no
// branch is accepted until every entry is cleared; register writes are taken
// throughout. A new branch is accepted while a result word still waits.
module bimodal_branch_predictor #(
  parameter int TABLE_ENTRIES    = bbp_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_COUNTER_BITS = bbp_pkg::MAX_COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          branch_valid,
  output logic                          branch_ready,
  input  bbp_pkg::branch_word_t         branch,
  output logic                          result_valid,
  input  logic                          result_ready,
  output bbp_pkg::result_word_t         result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbp_pkg::PADDR_W-1:0]   paddr,
  input  logic [bbp_pkg::PDATA_W-1:0]   pwdata,
  output logic [bbp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = MAX_COUNTER_BITS;
  localparam int SB = bbp_pkg::SEL_BITS;

  bbp_pkg::state_t   state, state_next;
  bbp_pkg::tbl_ctl_t tbl_ctl;

  logic [bbp_pkg::CFG_W-1:0] counter_bits;
  logic [IW-1:0]             clr_idx;
  logic [SB-1:0]             sel;
  logic                      taken;
  logic [IW-1:0]             slot;
  logic [IW-1:0]             slot_held;
  logic [IW-1:0]             tbl_addr;
  logic [CW-1:0]             tbl_wdata;
  logic [CW-1:0]             tbl_rdata;
  logic [31:0]               hit_count;
  logic [31:0]               miss_count;

  logic                      branch_fire;
  logic                      load_result;
  logic [3:0]                n_use;
  logic [CW-1:0]             top;
  logic [CW-1:0]             half;
  logic [CW-1:0]             cnt_sat;
  logic [CW-1:0]             cnt_new;
  logic                      guess;
  logic                      hit;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_bits <= bbp_pkg::COUNTER_BITS_RST;
    end else if (psel && penable && pwrite &&
                 paddr[2] == bbp_pkg::REG_COUNTER_BITS) begin
      counter_bits <= pwdata[bbp_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bbp_pkg::REG_COUNTER_BITS) begin
      prdata = bbp_pkg::PDATA_W'(counter_bits);
    end
  end

  assign branch_fire = branch_valid && branch_ready;

  always_ff @(posedge clk) begin
    if (branch_fire) begin
      sel   <= branch.branch_address[bbp_pkg::SEL_LSB +: SB];
      taken <= branch.taken;
    end
  end

  // entry select, modulo the table size
  generate
    if (TABLE_ENTRIES >= (1 << SB)) begin : g_sel_wide
      assign slot = IW'(sel);
    end else if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_sel_mask
      assign slot = sel[IW-1:0];
    end else begin : g_sel_recip
      localparam int RSH   = 20;
      localparam int RECIP = ((1 << RSH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
      logic [31:0]   prod;
      logic [SB-1:0] quot;
      logic [SB-1:0] rem;
      assign prod = 32'(branch.branch_address[bbp_pkg::SEL_LSB +: SB]) * 32'(RECIP);
      always_ff @(posedge clk) begin
        if (branch_fire) begin
          quot <= prod[RSH +: SB];
        end
      end
      assign rem  = sel - SB'(quot * SB'(TABLE_ENTRIES));
      assign slot = rem[IW-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (state == bbp_pkg::ST_INDEX) begin
      slot_held <= slot;
    end
  end

  // counter width in use and its bounds
  always_comb begin
    if (counter_bits == '0) begin
      n_use = 4'd1;
    end else if ({1'b0, counter_bits} > 5'(MAX_COUNTER_BITS)) begin
      n_use = 4'(MAX_COUNTER_BITS);
    end else begin
      n_use = counter_bits;
    end
  end

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      top[i]  = 5'(i) < {1'b0, n_use};
      half[i] = 5'(i) == ({1'b0, n_use} - 5'd1);
    end
  end

  always_comb begin
    cnt_sat = (tbl_rdata > top) ? top : tbl_rdata;
    guess   = cnt_sat >= half;
    hit     = guess == taken;
    cnt_new = cnt_sat;
    if (taken) begin
      if (cnt_sat != top) begin
        cnt_new = cnt_sat + CW'(1);
      end
    end else if (cnt_sat != '0) begin
      cnt_new = cnt_sat - CW'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bbp_pkg::ST_CLEAR: begin
        if (clr_idx == IW'(TABLE_ENTRIES - 1)) begin
          state_next = bbp_pkg::ST_IDLE;
        end
      end
      bbp_pkg::ST_IDLE: begin
        if (branch_valid) begin
          state_next = bbp_pkg::ST_INDEX;
        end
      end
      bbp_pkg::ST_INDEX: begin
        state_next = bbp_pkg::ST_UPDATE;
      end
      bbp_pkg::ST_UPDATE: begin
        if (!result_valid || result_ready) begin
          state_next = bbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    branch_ready = 1'b0;
    load_result  = 1'b0;
    tbl_ctl      = '0;
    tbl_addr     = slot_held;
    tbl_wdata    = cnt_new;
    case (state)
      bbp_pkg::ST_CLEAR: begin
        tbl_ctl.wr = 1'b1;
        tbl_addr   = clr_idx;
        tbl_wdata  = '0;
      end
      bbp_pkg::ST_IDLE: begin
        branch_ready = 1'b1;
      end
      bbp_pkg::ST_INDEX: begin
        tbl_ctl.rd = 1'b1;
        tbl_addr   = slot;
      end
      bbp_pkg::ST_UPDATE: begin
        if (!result_valid || result_ready) begin
          tbl_ctl.wr  = 1'b1;
          load_result = 1'b1;
        end
      end
      default: begin
        branch_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == bbp_pkg::ST_CLEAR) begin
      clr_idx <= clr_idx + IW'(1);
    end
  end

  bbp_table #(
    .ENTRIES (TABLE_ENTRIES),
    .WIDTH   (CW)
  ) u_table (
    .clk   (clk),
    .ctl   (tbl_ctl),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  // running totals, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count  <= '0;
      miss_count <= '0;
    end else if (load_result) begin
      if (hit && hit_count != '1) begin
        hit_count <= hit_count + 32'd1;
      end
      if (!hit && miss_count != '1) begin
        miss_count <= miss_count + 32'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.predicted_taken    <= guess;
      result.prediction_correct <= hit;
      result.hit_total          <= (hit && hit_count != '1) ? hit_count + 32'd1 : hit_count;
      result.miss_total         <= (!hit && miss_count != '1) ? miss_count + 32'd1 : miss_count;
    end
  end

  a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (rst)
    !(tbl_ctl.rd && tbl_ctl.wr))
    else $error("table read and write in the same cycle");

  a_index_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == bbp_pkg::ST_INDEX |-> $past(branch_valid && branch_ready))
    else $error("table read without an accepted branch");

  a_result_after_update: assert property (@(posedge clk) disable iff (rst)
    load_result |=> result_valid)
    else $error("result word lost after update");

  a_one_total_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(hit_count) |-> $stable(miss_count))
    else $error("hit and miss totals moved together");

  a_counter_in_range: assert property (@(posedge clk) disable iff (rst)
    load_result |-> cnt_new <= top)
    else $error("counter written above its maximum");

endmodule
